/* rtl/newton_square_root_core_macros.svh */
// assertion macros for the newton square root core
// included by the top level, which checks its own logic; no other dependencies
`ifndef NEWTON_SQUARE_ROOT_CORE_MACROS_SVH
`define NEWTON_SQUARE_ROOT_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define NSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nsr check failed");
// next-cycle implication, disabled while in reset
`define NSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nsr check failed");
`else
`define NSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define NSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/nsr_pkg.sv */
// shared types and constants of the newton square root core
// no dependencies
package nsr_pkg;

	localparam int IO_W  = 32;  // radicand and root port width
	localparam int CFG_W = 6;   // iteration count register width

	localparam logic [CFG_W-1:0] ITER_RESET = 6'd24;

	// sequencer of the top level
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_STEP,
		ST_OUT
	} nsr_state_t;

	// phases of one newton step
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MUL,
		PH_SUB,
		PH_DIV,
		PH_UPD
	} nsr_phase_t;

	// step unit status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} nsr_step_stat_t;

endpackage

/* rtl/nsr_in_if.sv */
// input channel of the newton square root core: valid/ready plus radicand
// depends on nsr_pkg
interface nsr_in_if;
	logic                       valid;
	logic                       ready;
	logic [nsr_pkg::IO_W-1:0]   radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

/* rtl/nsr_out_if.sv */
// output channel of the newton square root core: valid/ready plus result
// depends on nsr_pkg
interface nsr_out_if;
	logic                       valid;
	logic                       ready;
	logic [nsr_pkg::IO_W-1:0]   root;
	logic                       zero_divisor_stop;

	modport source (output valid, output root, output zero_divisor_stop, input ready);
	modport sink   (input valid, input root, input zero_divisor_stop, output ready);
endinterface

/* rtl/nsr_step.sv */
// one newton step y - (y*y - x<<frac) / (2y), bit-serial multiply and divide
// depends on nsr_pkg
module nsr_step #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DATA_WIDTH-1:0]      x,
	input  logic [DATA_WIDTH-1:0]      y,
	output logic [DATA_WIDTH-1:0]      y_next,
	output nsr_pkg::nsr_step_stat_t    stat
);

	// numerator width: holds y*y and x << frac
	localparam int NUM_W = (FRAC_BITS > DATA_WIDTH) ? DATA_WIDTH + FRAC_BITS : 2 * DATA_WIDTH;
	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DATA_WIDTH - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

	nsr_pkg::nsr_phase_t phase_q, phase_d;
	logic [CNT_W-1:0]        cnt_q;

	logic [2*DATA_WIDTH-1:0] prod_q;
	logic [DATA_WIDTH-1:0]   mplr_q;
	logic [NUM_W-1:0]        num_q;
	logic                    neg_q;
	logic [DATA_WIDTH-1:0]   rem_q;
	logic [DATA_WIDTH-1:0]   quo_q;
	logic                    ovf_q;

	logic [DATA_WIDTH:0]     mul_acc;
	logic [NUM_W-1:0]        sq_w, xs_w, diff_w;
	logic                    neg_w;
	logic [DATA_WIDTH:0]     rem_sh, rem_sub;
	logic                    div_ge;
	logic [DATA_WIDTH:0]     up_sum;

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			nsr_pkg::PH_IDLE: if (start) phase_d = nsr_pkg::PH_MUL;
			nsr_pkg::PH_MUL:  if (cnt_q == MUL_LAST) phase_d = nsr_pkg::PH_SUB;
			nsr_pkg::PH_SUB:  phase_d = nsr_pkg::PH_DIV;
			nsr_pkg::PH_DIV:  if (cnt_q == DIV_LAST) phase_d = nsr_pkg::PH_UPD;
			nsr_pkg::PH_UPD:  phase_d = nsr_pkg::PH_IDLE;
			default:          phase_d = nsr_pkg::PH_IDLE;
		endcase
	end

	// status outputs
	always_comb begin
		stat.busy = (phase_q != nsr_pkg::PH_IDLE);
		stat.done = (phase_q == nsr_pkg::PH_UPD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nsr_pkg::PH_IDLE;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (phase_q == nsr_pkg::PH_MUL || phase_q == nsr_pkg::PH_DIV) begin
				cnt_q <= (phase_d == phase_q) ? cnt_q + 1'b1 : '0;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// shift-add multiply: one multiplier bit per cycle
	assign mul_acc = {1'b0, prod_q[2*DATA_WIDTH-1:DATA_WIDTH]}
		+ (mplr_q[0] ? {1'b0, y} : '0);

	// signed numerator magnitude, halved for the 2y divisor
	assign sq_w   = NUM_W'(prod_q);
	assign xs_w   = NUM_W'(x) << FRAC_BITS;
	assign neg_w  = (sq_w < xs_w);
	assign diff_w = neg_w ? (xs_w - sq_w) : (sq_w - xs_w);

	// restoring division: one quotient bit per cycle
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign div_ge  = (rem_sh >= {1'b0, y});
	assign rem_sub = rem_sh - {1'b0, y};

	always_ff @(posedge clk) begin
		case (phase_q)
			nsr_pkg::PH_IDLE: begin
				prod_q <= '0;
				mplr_q <= y;
			end
			nsr_pkg::PH_MUL: begin
				prod_q <= {mul_acc, prod_q[DATA_WIDTH-1:1]};
				mplr_q <= mplr_q >> 1;
			end
			nsr_pkg::PH_SUB: begin
				num_q <= diff_w >> 1;
				neg_q <= neg_w;
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			nsr_pkg::PH_DIV: begin
				num_q <= num_q << 1;
				rem_q <= div_ge ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], div_ge};
				ovf_q <= ovf_q | quo_q[DATA_WIDTH-1];
			end
			default: begin
			end
		endcase
	end

	// apply the correction with saturation
	assign up_sum = {1'b0, y} + {1'b0, quo_q};

	always_comb begin
		if (neg_q) begin
			y_next = (ovf_q || up_sum[DATA_WIDTH]) ? '1 : up_sum[DATA_WIDTH-1:0];
		end else begin
			y_next = (ovf_q || quo_q > y) ? '0 : y - quo_q;
		end
	end

endmodule

/* rtl/newton_square_root_core.sv */
// newton square root core: top level with sequencer, config register and output stage
// depends on nsr_pkg, nsr_in_if, nsr_out_if, nsr_step and the assertion macro header
//
// usage
//   in_ch  : one beat carries an unsigned fixed point radicand (FRAC_BITS fraction bits)
//   out_ch : one beat per radicand, the root (saturated) and zero_divisor_stop
//   cfg_we / cfg_wdata : write the iteration count; write only while the core is idle
// timing
//   the core works on one radicand at a time; in_ch.ready is high while it waits
//   each newton step is a bit-serial multiply over the DATA_WIDTH multiplier bits, a
//   subtract, then a restoring divide over the NUM_W numerator bits (NUM_W =
//   max(2*DATA_WIDTH, DATA_WIDTH+FRAC_BITS)) and a final update of the root
//   an item runs iteration_count newton steps unless a check finds a zero root first;
//   with the reset count of 24 that is 24 steps, and with a count of zero no step runs
//   a zero radicand stops at the first step check and, unless the iteration count is zero, sets zero_divisor_stop
// reset
//   arst_n clears the sequencer and the output valid; the iteration count returns to 24
// back-pressure
//   the result sits in an output register; the next radicand is accepted while it
//   waits, and the core only holds before loading its own result into a full register
`include "newton_square_root_core_macros.svh"

module newton_square_root_core #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [nsr_pkg::CFG_W-1:0]   cfg_wdata,
	nsr_in_if.sink                      in_ch,
	nsr_out_if.source                   out_ch
);

	// sequencer state
	nsr_pkg::nsr_state_t state_q, state_d;

	// configuration: iteration count per radicand
	logic [nsr_pkg::CFG_W-1:0] iter_q;

	// working values of the current radicand
	logic [DATA_WIDTH-1:0]     x_q;
	logic [DATA_WIDTH-1:0]     y_q;
	logic [nsr_pkg::CFG_W-1:0] k_q;      // steps done so far
	logic                      stop_q;   // zero divisor seen

	// output register
	logic                      out_valid_q;
	logic [nsr_pkg::IO_W-1:0]  root_q;
	logic                      zstop_q;

	// control decode
	logic in_beat;
	logic iter_done;
	logic step_start;
	logic load_out;

	// step unit link
	logic [DATA_WIDTH-1:0]     y_next;
	nsr_pkg::nsr_step_stat_t   stat;

	assign in_beat   = in_ch.valid && in_ch.ready;
	assign iter_done = (k_q == iter_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nsr_pkg::ST_IDLE: if (in_beat) state_d = nsr_pkg::ST_CHECK;
			nsr_pkg::ST_CHECK: begin
				// all steps done, or divisor 2y would be zero
				if (iter_done || y_q == '0) state_d = nsr_pkg::ST_OUT;
				else state_d = nsr_pkg::ST_STEP;
			end
			nsr_pkg::ST_STEP: if (stat.done) state_d = nsr_pkg::ST_CHECK;
			nsr_pkg::ST_OUT: if (!out_valid_q || out_ch.ready) state_d = nsr_pkg::ST_IDLE;
			default: state_d = nsr_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ch.ready = (state_q == nsr_pkg::ST_IDLE);
		step_start  = (state_q == nsr_pkg::ST_CHECK) && !iter_done && (y_q != '0);
		load_out    = (state_q == nsr_pkg::ST_OUT) && (!out_valid_q || out_ch.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nsr_pkg::ST_IDLE;
			iter_q      <= nsr_pkg::ITER_RESET;
			k_q         <= '0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) iter_q <= cfg_wdata;

			if (in_beat) begin
				k_q    <= '0;
				stop_q <= 1'b0;
			end else if (state_q == nsr_pkg::ST_CHECK && !iter_done && y_q == '0) begin
				stop_q <= 1'b1;
			end else if (stat.done) begin
				k_q <= k_q + 1'b1;
			end

			// output beat leaves on ready, a new result takes its place
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			x_q <= DATA_WIDTH'(in_ch.radicand);
			y_q <= DATA_WIDTH'(in_ch.radicand);
		end else if (stat.done) begin
			y_q <= y_next;
		end
		if (load_out) begin
			root_q  <= nsr_pkg::IO_W'(y_q);
			zstop_q <= stop_q;
		end
	end

	nsr_step #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_start),
		.x      (x_q),
		.y      (y_q),
		.y_next (y_next),
		.stat   (stat)
	);

	assign out_ch.valid             = out_valid_q;
	assign out_ch.root              = root_q;
	assign out_ch.zero_divisor_stop = zstop_q;

	// the step unit only reports done while the sequencer waits on it
	`NSR_ASSERT_NOW(a_done_in_step, clk, arst_n, stat.done, state_q == nsr_pkg::ST_STEP)
	// a step is never started on a busy unit
	`NSR_ASSERT_NOW(a_start_idle_unit, clk, arst_n, step_start, !stat.busy)
	// the step count never passes the configured count while working
	`NSR_ASSERT_NOW(a_k_bounded, clk, arst_n, state_q != nsr_pkg::ST_IDLE, k_q <= iter_q)
	// the zero divisor flag only stands with a zero root
	`NSR_ASSERT_NOW(a_stop_zero, clk, arst_n, stop_q && state_q != nsr_pkg::ST_IDLE, y_q == '0)
	// a loaded result is presented in the next cycle
	`NSR_ASSERT_NEXT(a_load_shows, clk, arst_n, load_out, out_valid_q)

endmodule
